// ----- rtl/dpvp_pkg.sv -----
package dpvp_pkg;

    localparam int IN_W   = 20;
    localparam int N_W    = 5;
    localparam int MANT_W = 31;
    localparam int FRAC_W = 16;
    localparam int LOG_W  = N_W + FRAC_W;
    localparam int STEPS  = 16;
    localparam int LQ_W   = 23;
    localparam int AB_W   = 26;
    localparam int NUM_W  = 49;
    localparam int DEN_W  = 38;
    localparam int REM_W  = 61;
    localparam int QW     = 20;
    localparam int OUT_W  = 16;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic signed [AB_W-1:0] WATER_A = 26'sd15551693;
    localparam logic signed [AB_W-1:0] WATER_B = 26'sd1131807;
    localparam logic signed [AB_W-1:0] ICE_A   = 26'sd17399808;
    localparam logic signed [AB_W-1:0] ICE_B   = 26'sd1433272;
    localparam logic [OUT_W-1:0] T_MIN = 16'h8000;
    localparam logic [OUT_W-1:0] T_MAX = 16'h7FFF;

    typedef struct packed {
        logic vld;
        logic ice;
        logic inv;
        logic neg;
        logic dbad;
    } t_side;

    // elaboration-time log2 in Q16, same steps as the hardware
    function automatic logic [LOG_W-1:0] log2_q16(input logic [63:0] x);
        logic [63:0] m;
        logic [5:0]  n;
        logic [FRAC_W-1:0] f;
        n = '0;
        f = '0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                n = 6'(i);
            end
        end
        m = x << (6'd30 - n);
        for (int k = 0; k < STEPS; k++) begin
            m = (m * m) >> 30;
            f = {f[FRAC_W-2:0], m[31]};
            if (m[31]) begin
                m = m >> 1;
            end
        end
        return {n[N_W-1:0], f};
    endfunction

endpackage

// ----- rtl/dpvp_log2.sv -----
module dpvp_log2 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dpvp_pkg::t_side            i_side,
    input  logic [dpvp_pkg::IN_W-1:0]  i_x,
    output dpvp_pkg::t_side            o_side,
    output logic [dpvp_pkg::LOG_W-1:0] o_log
);

    localparam int S = dpvp_pkg::STEPS;

    dpvp_pkg::t_side                r_side [0:S];
    logic [dpvp_pkg::MANT_W-1:0]    r_m    [0:S];
    logic [dpvp_pkg::FRAC_W-1:0]    r_frac [0:S];
    logic [dpvp_pkg::N_W-1:0]       r_n    [0:S];

    logic [dpvp_pkg::N_W-1:0]       n_n;
    logic [dpvp_pkg::MANT_W-1:0]    n_m;
    logic [2*dpvp_pkg::MANT_W-1:0]  sq  [0:S-1];
    logic [dpvp_pkg::MANT_W:0]      sh  [0:S-1];

    always_comb begin
        n_n = '0;
        for (int i = 0; i < dpvp_pkg::IN_W; i++) begin
            if (i_x[i]) begin
                n_n = dpvp_pkg::N_W'(i);
            end
        end
        n_m = dpvp_pkg::MANT_W'(i_x) << (5'd30 - n_n);
    end

    always_comb begin
        for (int k = 0; k < S; k++) begin
            sq[k] = (2*dpvp_pkg::MANT_W)'(r_m[k]) * (2*dpvp_pkg::MANT_W)'(r_m[k]);
            sh[k] = sq[k][2*dpvp_pkg::MANT_W-1:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= S; k++) begin
                r_side[k] <= '0;
            end
        end else begin
            r_side[0] <= i_side;
            for (int k = 0; k < S; k++) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m[0]    <= n_m;
        r_n[0]    <= n_n;
        r_frac[0] <= '0;
        for (int k = 0; k < S; k++) begin
            r_n[k+1]    <= r_n[k];
            r_frac[k+1] <= {r_frac[k][dpvp_pkg::FRAC_W-2:0], sh[k][dpvp_pkg::MANT_W]};
            if (sh[k][dpvp_pkg::MANT_W]) begin
                r_m[k+1] <= sh[k][dpvp_pkg::MANT_W:1];
            end else begin
                r_m[k+1] <= sh[k][dpvp_pkg::MANT_W-1:0];
            end
        end
    end

    assign o_side = r_side[S];
    assign o_log  = {r_n[S], r_frac[S]};

endmodule

// ----- rtl/dpvp_div.sv -----
module dpvp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dpvp_pkg::t_side            i_side,
    input  logic [dpvp_pkg::REM_W-1:0] i_num,
    input  logic [dpvp_pkg::DEN_W-1:0] i_den,
    output dpvp_pkg::t_side            o_side,
    output logic [dpvp_pkg::QW-1:0]    o_q
);

    localparam int Q = dpvp_pkg::QW;

    dpvp_pkg::t_side               r_side [0:Q];
    logic [dpvp_pkg::REM_W-1:0]    r_rem  [0:Q];
    logic [dpvp_pkg::DEN_W-1:0]    r_d    [0:Q];
    logic [Q-1:0]                  r_q    [0:Q];
    logic [dpvp_pkg::REM_W:0]      trial  [0:Q-1];

    always_comb begin
        for (int k = 0; k < Q; k++) begin
            trial[k] = {1'b0, r_rem[k]}
                     - ((dpvp_pkg::REM_W+1)'(r_d[k]) << (Q - 1 - k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Q; k++) begin
                r_side[k] <= '0;
            end
        end else begin
            r_side[0] <= i_side;
            for (int k = 0; k < Q; k++) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_d[0]   <= i_den;
        r_q[0]   <= '0;
        for (int k = 0; k < Q; k++) begin
            r_d[k+1] <= r_d[k];
            if (!trial[k][dpvp_pkg::REM_W]) begin
                r_rem[k+1] <= trial[k][dpvp_pkg::REM_W-1:0];
                r_q[k+1]   <= {r_q[k][Q-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= r_rem[k];
                r_q[k+1]   <= {r_q[k][Q-2:0], 1'b0};
            end
        end
    end

    assign o_side = r_side[Q];
    assign o_q    = r_q[Q];

endmodule

// ----- rtl/dew_point_from_vapor_pressure.sv -----
// Dew point from water vapor pressure by the inverted Magnus formula. Pulse start with a
// pressure sample (1/2^IN_FRAC_BITS Pa); busy is always low, so a new sample can go in
// every cycle. Each result comes out with o_strobe high for one cycle and cannot be
// held off; it passes the 16-step squaring log2 pipeline and the 20-step restoring
// divider. Zero pressure flags o_invalid and reports the minimum value; out-of-range
// results saturate and flag o_saturated.
module dew_point_from_vapor_pressure #(
    parameter int IN_FRAC_BITS  = 4,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dpvp_pkg::IN_W-1:0]  i_vapor_pressure,
    output logic                       o_strobe,
    output logic signed [15:0]         o_dew_point,
    output logic                       o_over_ice,
    output logic                       o_invalid,
    output logic                       o_saturated
);

    localparam int LAT = 44;
    localparam logic [dpvp_pkg::IN_W-1:0] REF_P =
        dpvp_pkg::IN_W'(611 << IN_FRAC_BITS);
    localparam logic [dpvp_pkg::LOG_W-1:0] LREF =
        dpvp_pkg::log2_q16(64'(REF_P));

    dpvp_pkg::t_side in_side, log_side, div_side;
    logic [dpvp_pkg::LOG_W-1:0] log_val;
    logic [dpvp_pkg::QW-1:0]    div_q;

    dpvp_pkg::t_side r_sa, r_sb, r_sc, r_sd, r_se;
    logic signed [dpvp_pkg::LOG_W:0]     r_l2;
    logic signed [52:0]                  r_prod;
    logic signed [dpvp_pkg::LQ_W-1:0]    r_lq;
    logic signed [dpvp_pkg::NUM_W-1:0]   r_num;
    logic signed [dpvp_pkg::AB_W-1:0]    r_den;
    logic [dpvp_pkg::REM_W-1:0]          r_n;
    logic [dpvp_pkg::DEN_W-1:0]          r_dd;

    logic                                r_strobe, r_ice, r_inv, r_sat;
    logic [15:0]                         r_t;

    logic [52:0]                         c_amag;
    logic [23:0]                         c_rr;
    logic signed [dpvp_pkg::AB_W-1:0]    c_a, c_b, c_den;
    logic [dpvp_pkg::NUM_W-1:0]          c_nmag;
    logic [dpvp_pkg::REM_W-1:0]          c_mag;
    logic [dpvp_pkg::DEN_W-1:0]          c_d;
    logic                                f_sat;
    logic [15:0]                         f_t;

    assign busy = 1'b0;

    always_comb begin
        in_side      = '0;
        in_side.vld  = start;
        in_side.ice  = (i_vapor_pressure <= REF_P);
        in_side.inv  = (i_vapor_pressure == '0);
    end

    dpvp_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (in_side),
        .i_x     (i_vapor_pressure),
        .o_side  (log_side),
        .o_log   (log_val)
    );

    always_comb begin
        c_amag = r_prod[52] ? 53'(-r_prod) : 53'(r_prod);
        c_rr   = 24'((c_amag + 53'(1 << 29)) >> 30);
        c_a    = r_sc.ice ? dpvp_pkg::ICE_A : dpvp_pkg::WATER_A;
        c_b    = r_sc.ice ? dpvp_pkg::ICE_B : dpvp_pkg::WATER_B;
        c_den  = c_b - dpvp_pkg::AB_W'(r_lq);
        c_nmag = r_num[dpvp_pkg::NUM_W-1] ? dpvp_pkg::NUM_W'(-r_num)
                                          : dpvp_pkg::NUM_W'(r_num);
        c_mag  = dpvp_pkg::REM_W'(c_nmag) << OUT_FRAC_BITS;
        c_d    = dpvp_pkg::DEN_W'(r_den[21:0]) << 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= '0;
            r_sb <= '0;
            r_sc <= '0;
            r_sd <= '0;
            r_se <= '0;
        end else begin
            r_sa <= log_side;
            r_sb <= r_sa;
            r_sc <= r_sb;
            r_sd <= '{vld: r_sc.vld, ice: r_sc.ice, inv: r_sc.inv, neg: r_sc.neg,
                      dbad: (c_den[dpvp_pkg::AB_W-1] || c_den == '0)};
            r_se <= '{vld: r_sd.vld, ice: r_sd.ice, inv: r_sd.inv,
                      neg: r_num[dpvp_pkg::NUM_W-1], dbad: r_sd.dbad};
        end
    end

    always_ff @(posedge i_clk) begin
        r_l2   <= $signed({1'b0, log_val}) - $signed({1'b0, LREF});
        r_prod <= 53'(r_l2) * $signed(53'(dpvp_pkg::LN2_Q30));
        r_lq   <= r_prod[52] ? -dpvp_pkg::LQ_W'(c_rr) : dpvp_pkg::LQ_W'(c_rr);
        r_num  <= dpvp_pkg::NUM_W'(c_a) * dpvp_pkg::NUM_W'(r_lq);
        r_den  <= c_den;
        r_n    <= c_mag + (c_d >> 1);
        r_dd   <= c_d;
    end

    dpvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_se),
        .i_num   (r_n),
        .i_den   (r_dd),
        .o_side  (div_side),
        .o_q     (div_q)
    );

    always_comb begin
        f_sat = 1'b0;
        f_t   = div_q[15:0];
        if (div_side.neg) begin
            f_sat = (div_q > dpvp_pkg::QW'(32768));
            f_t   = f_sat ? dpvp_pkg::T_MIN : 16'(~div_q + 1'b1);
        end else begin
            f_sat = (div_q > dpvp_pkg::QW'(32767));
            f_t   = f_sat ? dpvp_pkg::T_MAX : div_q[15:0];
        end
        if (div_side.dbad) begin
            f_sat = 1'b1;
            f_t   = dpvp_pkg::T_MAX;
        end
        if (div_side.inv) begin
            f_sat = 1'b0;
            f_t   = dpvp_pkg::T_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= div_side.vld;
        end
        r_t   <= f_t;
        r_ice <= div_side.ice;
        r_inv <= div_side.inv;
        r_sat <= f_sat;
    end

    assign o_strobe    = r_strobe;
    assign o_dew_point = $signed(r_t);
    assign o_over_ice  = r_ice;
    assign o_invalid   = r_inv;
    assign o_saturated = r_sat;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_strobe)
        else $error("result beat missing");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result beat without sample");

    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_invalid) |->
            (o_dew_point == $signed(dpvp_pkg::T_MIN) && o_over_ice && !o_saturated))
        else $error("invalid beat malformed");

    a_water_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_over_ice) |-> !o_invalid)
        else $error("invalid flagged over water");

endmodule

// ----- sim/dew_point_from_vapor_pressure_tb.sv -----
`timescale 1ns / 100ps

class dew_scoreboard;
    typedef struct {
        logic signed [15:0] dew_point;
        logic over_ice;
        logic invalid;
        logic saturated;
    } dew_result_t;

    dew_result_t pending_q[$];
    int errors = 0;

    function automatic longint log2_q16(longint unsigned x);
        int n;
        longint unsigned m;
        longint unsigned frac;
        n = 0;
        frac = 0;
        if (x == 0) return 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) n = i;
        end
        m = x << (30 - n);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(n) << 16) | longint'(frac);
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint unsigned half;
        half = 64'd1 << (s - 1);
        if (v < 0) return -longint'((unsigned'(-v) + half) >> s);
        return longint'((unsigned'(v) + half) >> s);
    endfunction

    function void note_sample(logic [19:0] p_in);
        dew_result_t r;
        longint unsigned p;
        longint unsigned ref_p;
        longint a;
        longint b;
        longint lq;
        longint den;
        longint num;
        longint t;
        longint unsigned mag;
        longint unsigned d;
        longint unsigned q;
        p = p_in;
        ref_p = 611 << 4;
        r.over_ice = (p <= ref_p);
        r.invalid = 0;
        r.saturated = 0;
        a = r.over_ice ? 64'(dpvp_pkg::ICE_A) : 64'(dpvp_pkg::WATER_A);
        b = r.over_ice ? 64'(dpvp_pkg::ICE_B) : 64'(dpvp_pkg::WATER_B);
        if (p == 0) begin
            r.dew_point = 16'sh8000;
            r.invalid = 1;
        end else begin
            lq = round_shift((log2_q16(p) - log2_q16(ref_p)) * 64'd744261118, 30);
            den = b - lq;
            if (den <= 0) begin
                t = 32767;
                r.saturated = 1;
            end else begin
                num = a * lq;
                mag = unsigned'(num < 0 ? -num : num) * 256;
                d = unsigned'(den) << 16;
                q = (mag + d / 2) / d;
                if (q > 40000) q = 40000;
                t = (num < 0) ? -longint'(q) : longint'(q);
                if (t > 32767) begin
                    t = 32767;
                    r.saturated = 1;
                end else if (t < -32768) begin
                    t = -32768;
                    r.saturated = 1;
                end
            end
            r.dew_point = t[15:0];
        end
        pending_q.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] dp, logic ice, logic inv, logic sat);
        dew_result_t e;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result dp=%0d", $time, dp);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (dp !== e.dew_point) begin
            $display("%0t: dew_point exp %0d got %0d", $time, e.dew_point, dp);
            errors++;
        end
        if (ice !== e.over_ice) begin
            $display("%0t: over_ice exp %0b got %0b", $time, e.over_ice, ice);
            errors++;
        end
        if (inv !== e.invalid) begin
            $display("%0t: invalid exp %0b got %0b", $time, e.invalid, inv);
            errors++;
        end
        if (sat !== e.saturated) begin
            $display("%0t: saturated exp %0b got %0b", $time, e.saturated, sat);
            errors++;
        end
    endfunction
endclass

module dew_point_from_vapor_pressure_tb;
    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [19:0] i_vapor_pressure;
    logic o_strobe;
    logic signed [15:0] o_dew_point;
    logic o_over_ice;
    logic o_invalid;
    logic o_saturated;

    dew_scoreboard sb;
    bit quiet_tail;

    dew_point_from_vapor_pressure dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_vapor_pressure(i_vapor_pressure),
        .o_strobe(o_strobe),
        .o_dew_point(o_dew_point),
        .o_over_ice(o_over_ice),
        .o_invalid(o_invalid),
        .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result(o_dew_point, o_over_ice, o_invalid, o_saturated);
        end
        if (i_rst_n && start && !busy) begin
            sb.note_sample(i_vapor_pressure);
        end
    end

    // drive one beat; start stays high across back-to-back beats
    task automatic send_sample(logic [19:0] p);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_vapor_pressure <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [19:0] random_pressure();
        case ($urandom_range(0, 5))
            0: return 20'($urandom);
            1: return 20'($urandom_range(0, 255));
            2: return 20'($urandom_range(9776 - 40, 9776 + 40));
            3: return 20'($urandom_range(1, 9776));
            4: return 20'($urandom) >> $urandom_range(0, 19);
            default: return 20'($urandom_range(9777, 200000));
        endcase
    endfunction

    initial begin
        static logic [19:0] directed[$] = '{20'd0, 20'd1, 20'd2, 20'd3, 20'd16, 20'd9775,
            20'd9776, 20'd9777, 20'd9792, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'd160,
            20'd40000, 20'd100000, 20'hAAAAA, 20'h55555, 20'd4888, 20'd1000, 20'd500000};
        int wait_cycles;
        sb = new();
        i_rst_n = 0;
        start = 0;
        i_vapor_pressure = '0;
        quiet_tail = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (directed[k]) send_sample(directed[k]);
        for (int k = 0; k < 1150; k++) begin
            if (k > 1000) quiet_tail = 1;
            send_sample(random_pressure());
        end
        start <= 0;
        wait_cycles = 0;
        while (sb.pending_q.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
